FILE: src/ipv4hv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4hv_pkg
// Shared types and constants for the IPv4 header validator.
// ----------------------------------------------------------------------------
package ipv4hv_pkg;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_BAD_VER   = 3'd2,
    VERDICT_BAD_IHL   = 3'd3,
    VERDICT_BAD_LEN   = 3'd4,
    VERDICT_TRUNCATED = 3'd5,
    VERDICT_BAD_CSUM  = 3'd6
  } verdict_e;

  localparam logic [17:0] MIN_PKT_BYTES  = 18'd20;
  localparam logic [3:0]  IPV4_VERSION   = 4'd4;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [15:0] SUM_SEED       = 16'hFFFF;
  localparam logic [15:0] WORD_COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic        last_odd;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [5:0]  header_bytes;
    logic [15:0] total_length;
    logic [15:0] payload_length;
  } out_word_t;

  // handshake between the check stage and the result register
  typedef struct packed {
    logic load;   // result register takes a new word
    logic free;   // result register can take a word this cycle
  } res_ctrl_t;

endpackage

FILE: src/ipv4hv_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4hv_in_stage
// Input register: holds one packet word until the check stage consumes it.
// ----------------------------------------------------------------------------
module ipv4hv_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ipv4hv_pkg::in_word_t in_data_i,
  input  logic                 adv_i,
  output logic                 valid_o,
  output ipv4hv_pkg::in_word_t data_o
);

  logic                 valid_q, valid_d;
  ipv4hv_pkg::in_word_t data_q;
  logic                 take;

  assign in_ready_o = !valid_q || adv_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: src/ipv4hv_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4hv_check
// Per-packet state, checksum accumulate and verdict logic.
// ----------------------------------------------------------------------------
module ipv4hv_check (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  ipv4hv_pkg::in_word_t  data_i,
  output logic                  adv_o,
  input  ipv4hv_pkg::res_ctrl_t res_i,
  output logic                  load_o,
  output ipv4hv_pkg::out_word_t res_o
);

  logic [15:0] word_count_q, word_count_d;
  logic [7:0]  version_ihl_q, version_ihl_d;
  logic [15:0] length_field_q, length_field_d;
  logic [15:0] sum_acc_q, sum_acc_d;

  logic [7:0]  vi_cur;
  logic [15:0] len_cur;
  logic [3:0]  ihl;
  logic [16:0] sum_raw;
  logic [15:0] sum_cur;
  logic [17:0] bytes;
  logic [5:0]  hdr;

  assign adv_o  = valid_i && (!data_i.last || res_i.free);
  assign load_o = adv_o && data_i.last;

  always_comb begin
    vi_cur  = (word_count_q == 16'd0) ? data_i.word[15:8] : version_ihl_q;
    len_cur = (word_count_q == 16'd1) ? data_i.word : length_field_q;
    ihl     = vi_cur[3:0];
    sum_raw = {1'b0, sum_acc_q} + {1'b0, data_i.word};
    // end-around carry; cannot overflow a second time
    if (word_count_q < {11'd0, ihl, 1'b0}) begin
      sum_cur = sum_raw[15:0] + {15'd0, sum_raw[16]};
    end else begin
      sum_cur = sum_acc_q;
    end
    bytes = {1'b0, word_count_q, 1'b0} + 18'd2 - {17'd0, data_i.last_odd};
    hdr   = {ihl, 2'b00};
  end

  always_comb begin
    res_o.header_bytes   = hdr;
    res_o.total_length   = len_cur;
    res_o.payload_length = 16'd0;
    if (bytes < ipv4hv_pkg::MIN_PKT_BYTES) begin
      res_o.verdict      = ipv4hv_pkg::VERDICT_SHORT;
      res_o.header_bytes = 6'd0;
      res_o.total_length = 16'd0;
    end else if (vi_cur[7:4] != ipv4hv_pkg::IPV4_VERSION) begin
      res_o.verdict = ipv4hv_pkg::VERDICT_BAD_VER;
    end else if (ihl < ipv4hv_pkg::IHL_MIN) begin
      res_o.verdict = ipv4hv_pkg::VERDICT_BAD_IHL;
    end else if (len_cur < {10'd0, hdr}) begin
      res_o.verdict = ipv4hv_pkg::VERDICT_BAD_LEN;
    end else if (bytes < {2'b00, len_cur}) begin
      res_o.verdict = ipv4hv_pkg::VERDICT_TRUNCATED;
    end else if (sum_cur != ipv4hv_pkg::SUM_SEED) begin
      res_o.verdict = ipv4hv_pkg::VERDICT_BAD_CSUM;
    end else begin
      res_o.verdict        = ipv4hv_pkg::VERDICT_OK;
      res_o.payload_length = len_cur - {10'd0, hdr};
    end
  end

  always_comb begin
    word_count_d   = word_count_q;
    version_ihl_d  = version_ihl_q;
    length_field_d = length_field_q;
    sum_acc_d      = sum_acc_q;
    if (adv_o) begin
      if (data_i.last) begin
        word_count_d   = 16'd0;
        version_ihl_d  = 8'd0;
        length_field_d = 16'd0;
        sum_acc_d      = ipv4hv_pkg::SUM_SEED;
      end else begin
        version_ihl_d  = vi_cur;
        length_field_d = len_cur;
        sum_acc_d      = sum_cur;
        if (word_count_q != ipv4hv_pkg::WORD_COUNT_MAX) begin
          word_count_d = word_count_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q   <= 16'd0;
      version_ihl_q  <= 8'd0;
      length_field_q <= 16'd0;
      sum_acc_q      <= ipv4hv_pkg::SUM_SEED;
    end else begin
      word_count_q   <= word_count_d;
      version_ihl_q  <= version_ihl_d;
      length_field_q <= length_field_d;
      sum_acc_q      <= sum_acc_d;
    end
  end

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |=> (word_count_q == 16'd0) && (sum_acc_q == ipv4hv_pkg::SUM_SEED))
    else $error("state not restarted after last word");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_o && !data_i.last && (word_count_q != ipv4hv_pkg::WORD_COUNT_MAX))
    |=> (word_count_q == $past(word_count_q) + 16'd1))
    else $error("word count did not step");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_o |=> $stable(word_count_q) && $stable(sum_acc_q))
    else $error("state moved without a consumed word");

  a_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_o && (res_o.verdict != ipv4hv_pkg::VERDICT_OK)) |-> (res_o.payload_length == 16'd0))
    else $error("payload length set on failed verdict");

endmodule

FILE: src/ipv4hv_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4hv_out_stage
// Result register: holds one verdict word until the sink takes it.
// ----------------------------------------------------------------------------
module ipv4hv_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  ipv4hv_pkg::out_word_t data_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ipv4hv_pkg::out_word_t out_data_o
);

  logic                  valid_q, valid_d;
  ipv4hv_pkg::out_word_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: src/ipv4_header_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_validator_top
// IPv4 header validator: checks version, IHL, lengths and header checksum
// of a packet streamed as 16-bit words, one verdict word per packet.
// ----------------------------------------------------------------------------
// Throughput: one packet word per cycle, sustained, while the sink keeps up.
// A verdict passes through the input register and then the result register:
//   the check logic loads the result register from the input one.
// The rate is set by the combinational checksum add and length compares.
// Reset (rst_ni low, asynchronous): both registers empty, word count zero,
//   checksum accumulator back to its 0xFFFF seed.
module ipv4_header_validator_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ipv4hv_pkg::in_word_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ipv4hv_pkg::out_word_t out_data_o
);

  // word held in the input register
  logic                  stg_valid;
  ipv4hv_pkg::in_word_t  stg_data;
  // check stage consumes the held word this cycle
  logic                  adv;
  ipv4hv_pkg::res_ctrl_t res_ctrl;
  ipv4hv_pkg::out_word_t res_data;
  logic                  res_load;
  logic                  res_free;

  always_comb begin
    res_ctrl.load = res_load;
    res_ctrl.free = res_free;
  end

  // Input register. A new word enters whenever the held one moves on, so
  // words stream at full rate except while a last word is held back.
  ipv4hv_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .adv_i      (adv),
    .valid_o    (stg_valid),
    .data_o     (stg_data)
  );

  // Header state and verdict. Only a last word waits on the result register;
  // other words are consumed unconditionally.
  ipv4hv_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid),
    .data_i  (stg_data),
    .adv_o   (adv),
    .res_i   (res_ctrl),
    .load_o  (res_load),
    .res_o   (res_data)
  );

  // Result register: parts the sink from the input side.
  ipv4hv_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_ctrl.load),
    .data_i      (res_data),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
